[src/amx_pkg.sv]
// ----------------------------------------------------------------------------
// amx_pkg
// Shared types, constants and helper functions for the streaming argmax block.
// ----------------------------------------------------------------------------
`default_nettype none

package amx_pkg;

  localparam int unsigned MaxLength = 65536;

  // Most negative finite double, raw pattern
  localparam logic [63:0] LowBits = 64'hFFEF_FFFF_FFFF_FFFF;

  // Tie rule codes
  localparam logic [1:0] TIE_RANDOM = 2'd0;
  localparam logic [1:0] TIE_FIRST  = 2'd1;
  localparam logic [1:0] TIE_LAST   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_NONE    = 2'd2;

  // Register indexes
  localparam logic [0:0] REG_TIE_MODE = 1'd0;
  localparam logic [0:0] REG_DROP_NAN = 1'd1;

  typedef struct packed {
    logic [1:0] tie_mode;
    logic       drop_nan;
  } cfg_t;

  // Map a double onto an unsigned key whose order matches the numeric order
  // (for non-NaN values; both zeros map to distinct keys, handled apart).
  function automatic logic [63:0] order_key(input logic [63:0] b);
    order_key = b[63] ? ~b : {1'b1, b[62:0]};
  endfunction

  function automatic logic is_nan(input logic [63:0] b);
    is_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
  endfunction

  function automatic logic is_zero(input logic [63:0] b);
    is_zero = (b[62:0] == 63'd0);
  endfunction

endpackage

`default_nettype wire

[src/argmax_with_tie_modes_core.sv]
// ----------------------------------------------------------------------------
// argmax_with_tie_modes_core
// Streaming argmax over IEEE doubles with selectable tie rule.
// ----------------------------------------------------------------------------
// Takes one double per cycle and emits one result (position, status) on the
// item marked last. Each item passes through one compare stage into a result
// register. A one-entry skid buffer catches a result that arrives while the
// output is stalled; input pauses while that entry is in use or about to be
// filled, so with the output ready the sustained rate is one item per cycle.
// The result of the last item is captured in the tracker's result register and
// then in the output register, or in the skid entry while the output is
// stalled. Configure tie_mode and drop_nan only while no sequence is in progress.
`default_nettype none

module argmax_with_tie_modes_core #(
  parameter int unsigned MAX_LENGTH = amx_pkg::MaxLength,
  localparam int unsigned CW = $clog2(MAX_LENGTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [63:0]   value_bits,
  input  wire logic [31:0]   draw,
  input  wire logic          last,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [CW-1:0]      position,
  output logic [1:0]         status
);
  import amx_pkg::*;

  cfg_t          cfg;
  logic          step;
  logic          done;
  logic [CW-1:0] done_position;
  logic [1:0]    done_status;
  logic          skid_valid;
  logic [CW-1:0] skid_position;
  logic [1:0]    skid_status;

  amx_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // Accept while the skid entry is free and not about to be filled
  assign in_ready = !skid_valid && !(done && out_valid && !out_ready);
  assign step     = in_valid && in_ready;

  amx_track #(.MAX_LENGTH(MAX_LENGTH)) u_track (
    .clk, .rst, .cfg, .step, .value_bits, .draw, .last,
    .done, .done_position, .done_status
  );

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_ready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= done;
        end else begin
          out_valid <= done;
        end
      end else if (done) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        position <= skid_position;
        status   <= skid_status;
        if (done) begin
          skid_position <= done_position;
          skid_status   <= done_status;
        end
      end else if (done) begin
        position <= done_position;
        status   <= done_status;
      end
    end else if (done) begin
      skid_position <= done_position;
      skid_status   <= done_status;
    end
  end

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (done && out_valid && !out_ready) |=> skid_valid) else $error("result lost");
  a_skid_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid holds item without output");
  a_status_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_FOUND) |-> (position == '0))
    else $error("nonzero position with no result");

endmodule

`default_nettype wire

[src/amx_cfg.sv]
// ----------------------------------------------------------------------------
// amx_cfg
// APB register file for the tie rule and the NaN removal flag.
// ----------------------------------------------------------------------------
`default_nettype none

module amx_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output amx_pkg::cfg_t      cfg
);
  import amx_pkg::*;

  logic       wr_en;
  logic [0:0] reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[2:2];

  // Write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tie_mode <= TIE_FIRST;
      cfg.drop_nan <= 1'b0;
    end else if (wr_en && paddr[1:0] == 2'd0) begin
      unique case (reg_index)
        REG_TIE_MODE: cfg.tie_mode <= pwdata[1:0];
        REG_DROP_NAN: cfg.drop_nan <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = 32'd0;
    unique case (reg_index)
      REG_TIE_MODE: prdata = {30'd0, cfg.tie_mode};
      REG_DROP_NAN: prdata = {31'd0, cfg.drop_nan};
      default: prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

[src/amx_track.sv]
// ----------------------------------------------------------------------------
// amx_track
// Running maximum tracker: one compare and one tie decision per item.
// ----------------------------------------------------------------------------
`default_nettype none

module amx_track #(
  parameter int unsigned MAX_LENGTH = amx_pkg::MaxLength,
  localparam int unsigned CW = $clog2(MAX_LENGTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire amx_pkg::cfg_t cfg,
  input  wire logic          step,
  input  wire logic [63:0]   value_bits,
  input  wire logic [31:0]   draw,
  input  wire logic          last,
  output logic               done,
  output logic [CW-1:0]      done_position,
  output logic [1:0]         done_status
);
  import amx_pkg::*;

  logic [63:0]   best_key;
  logic [CW-1:0] best_position;
  logic [CW-1:0] tie_count;
  logic [CW-1:0] item_count;
  logic          nan_seen;

  logic [63:0]   best_key_next;
  logic [CW-1:0] best_position_next;
  logic [CW-1:0] tie_count_next;
  logic          nan_seen_next;
  logic [CW-1:0] pos;
  logic [63:0]   key;
  logic          nan;
  logic          in_range;
  logic [CW+31:0] prod;

  assign nan      = is_nan(value_bits);
  // Fold -0.0 onto +0.0 so the zeros tie
  assign key      = is_zero(value_bits) ? order_key(64'd0) : order_key(value_bits);
  assign in_range = item_count < CW'(MAX_LENGTH);
  assign pos      = item_count + CW'(1);
  assign prod     = (CW+32)'(tie_count + CW'(1)) * (CW+32)'(draw);

  // Update the running state for this item
  always_comb begin
    best_key_next      = best_key;
    best_position_next = best_position;
    tie_count_next     = tie_count;
    nan_seen_next      = nan_seen;
    if (in_range) begin
      if (nan) begin
        if (!cfg.drop_nan) nan_seen_next = 1'b1;
      end else if (key > best_key) begin
        best_key_next      = key;
        best_position_next = pos;
        tie_count_next     = CW'(1);
      end else if (key == best_key && best_position != '0) begin
        if (cfg.tie_mode == TIE_RANDOM) begin
          tie_count_next = tie_count + CW'(1);
          if (prod[CW+31:32] == '0) best_position_next = pos;
        end else if (cfg.tie_mode == TIE_LAST) begin
          best_position_next = pos;
        end
      end
    end
  end

  // Hold state, clear on the last item
  always_ff @(posedge clk) begin
    if (rst) begin
      best_key      <= order_key(LowBits);
      best_position <= '0;
      tie_count     <= '0;
      item_count    <= '0;
      nan_seen      <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= step && last;
      if (step) begin
        if (last) begin
          best_key      <= order_key(LowBits);
          best_position <= '0;
          tie_count     <= '0;
          item_count    <= '0;
          nan_seen      <= 1'b0;
        end else begin
          best_key      <= best_key_next;
          best_position <= best_position_next;
          tie_count     <= tie_count_next;
          if (in_range) item_count <= pos;
          nan_seen      <= nan_seen_next;
        end
      end
    end
  end

  // Capture the result on the last item
  always_ff @(posedge clk) begin
    if (step && last) begin
      if (nan_seen_next) begin
        done_position <= '0;
        done_status   <= ST_MISSING;
      end else if (best_position_next == '0) begin
        done_position <= '0;
        done_status   <= ST_NONE;
      end else begin
        done_position <= best_position_next;
        done_status   <= ST_FOUND;
      end
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    item_count <= CW'(MAX_LENGTH)) else $error("item count past limit");
  a_pos_le_count: assert property (@(posedge clk) disable iff (rst)
    best_position <= item_count) else $error("position past item count");
  a_tie_with_best: assert property (@(posedge clk) disable iff (rst)
    (best_position == '0) |-> (tie_count == '0)) else $error("tie without best");

endmodule

`default_nettype wire
